// ===== sv/mes_pkg.sv =====
// Shared types, control word layout and microcode program of the ellipse stepper.
`default_nettype none

package mes_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 12;
  localparam int unsigned DEC_W           = 50;
  localparam int unsigned PC_W            = 5;

  typedef logic [PC_W-1:0] pc_t;

  // input word modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef enum logic [2:0] {
    OA_SEMA, OA_SEMB, OA_BM1, OA_A, OA_B, OA_C1, OA_RM1
  } oa_e;

  typedef enum logic [2:0] {
    OB_SEMA, OB_SEMB, OB_PROD, OB_ROW, OB_ROWDEC, OB_COL, OB_RM1, OB_B
  } ob_e;

  typedef enum logic [1:0] {
    DO_HOLD, DO_LOAD, DO_ADD, DO_SUB
  } dop_e;

  typedef enum logic [1:0] {
    DS_PROD, DS_A, DS_B
  } dsrc_e;

  typedef enum logic [2:0] {
    JC_NONE, JC_ALWAYS, JC_CMP_GT, JC_DEC_NEG, JC_DEC_POS, JC_R2, JC_START, JC_ROW_ZERO
  } jc_e;

  typedef struct packed {
    logic       mul_en;
    oa_e        oa;
    ob_e        ob;
    logic       ld_a;
    logic       ld_b;
    logic       ld_tmp;
    dop_e       dop;
    dsrc_e      dsrc;
    logic [1:0] dsh;
    logic       row_dec;
    logic       col_inc;
    logic       set_r2;
    logic       emit;
    logic       clr_active;
    jc_e        jc;
    pc_t        jt;
    logic       fin;
  } uword_t;

  typedef struct packed {
    logic   run;
    logic   load_start;
    uword_t uw;
  } dp_ctl_t;

  typedef struct packed {
    logic active;
    logic in_r2;
    logic row_zero;
    logic dec_neg;
    logic dec_pos;
    logic cmp_gt;
    logic out_busy;
  } dp_stat_t;

  // program addresses
  localparam pc_t U_ST0  = 5'd0;
  localparam pc_t U_ST1  = 5'd1;
  localparam pc_t U_ST2  = 5'd2;
  localparam pc_t U_ST3  = 5'd3;
  localparam pc_t U_ST4  = 5'd4;
  localparam pc_t U_ST5  = 5'd5;
  localparam pc_t U_CK1  = 5'd6;
  localparam pc_t U_CK2  = 5'd7;
  localparam pc_t U_R20  = 5'd8;
  localparam pc_t U_R21  = 5'd9;
  localparam pc_t U_R22  = 5'd10;
  localparam pc_t U_R23  = 5'd11;
  localparam pc_t U_R24  = 5'd12;
  localparam pc_t U_R25  = 5'd13;
  localparam pc_t U_R26  = 5'd14;
  localparam pc_t U_END  = 5'd15;
  localparam pc_t U_EM   = 5'd16;
  localparam pc_t U_A10  = 5'd17;
  localparam pc_t U_A11  = 5'd18;
  localparam pc_t U_A11B = 5'd19;
  localparam pc_t U_A12  = 5'd20;
  localparam pc_t U_A13  = 5'd21;
  localparam pc_t U_A14  = 5'd22;
  localparam pc_t U_A20  = 5'd23;
  localparam pc_t U_A21  = 5'd24;
  localparam pc_t U_A22  = 5'd25;
  localparam pc_t U_A23  = 5'd26;
  localparam pc_t U_A23B = 5'd27;
  localparam pc_t U_A24  = 5'd28;
  localparam pc_t U_A25  = 5'd29;
  localparam pc_t U_A26  = 5'd30;
  localparam pc_t U_KILL = 5'd31;

  // A = a^2, B = b^2; the multiplier result is registered in prod before a later step uses it.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    w = '0;
    case (pc)
      // start: squares and region 1 seed 2A(b-1)b + A + 2B - 2AB
      U_ST0: begin
        w.mul_en = 1'b1; w.oa = OA_SEMA; w.ob = OB_SEMA;
      end
      U_ST1: begin
        w.ld_a = 1'b1; w.mul_en = 1'b1; w.oa = OA_SEMB; w.ob = OB_SEMB;
      end
      U_ST2: begin
        w.ld_b = 1'b1; w.dop = DO_LOAD; w.dsrc = DS_A;
        w.mul_en = 1'b1; w.oa = OA_BM1; w.ob = OB_SEMB;
      end
      U_ST3: begin
        w.dop = DO_ADD; w.dsrc = DS_B; w.dsh = 2'd1;
        w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_PROD;
      end
      U_ST4: begin
        w.dop = DO_ADD; w.dsrc = DS_PROD; w.dsh = 2'd1;
        w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_B;
      end
      U_ST5: begin
        w.dop = DO_SUB; w.dsrc = DS_PROD; w.dsh = 2'd1;
        w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_ROW;
      end
      // region test A*row > B*col
      U_CK1: begin
        w.ld_tmp = 1'b1; w.mul_en = 1'b1; w.oa = OA_B; w.ob = OB_COL;
      end
      U_CK2: begin
        w.jc = JC_CMP_GT; w.jt = U_END;
      end
      // region 2 seed 2B(c+1)c + 2A(r-1)^2 + B - 2AB
      U_R20: begin
        w.mul_en = 1'b1; w.oa = OA_C1; w.ob = OB_COL;
      end
      U_R21: begin
        w.mul_en = 1'b1; w.oa = OA_B; w.ob = OB_PROD;
      end
      U_R22: begin
        w.dop = DO_LOAD; w.dsrc = DS_PROD; w.dsh = 2'd1;
        w.mul_en = 1'b1; w.oa = OA_RM1; w.ob = OB_RM1;
      end
      U_R23: begin
        w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_PROD;
      end
      U_R24: begin
        w.dop = DO_ADD; w.dsrc = DS_PROD; w.dsh = 2'd1;
        w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_B;
      end
      U_R25: begin
        w.dop = DO_SUB; w.dsrc = DS_PROD; w.dsh = 2'd1;
      end
      U_R26: begin
        w.dop = DO_ADD; w.dsrc = DS_B; w.set_r2 = 1'b1;
      end
      U_END: begin
        w.jc = JC_START; w.jt = U_EM; w.fin = 1'b1;
      end
      U_EM: begin
        w.emit = 1'b1; w.jc = JC_R2; w.jt = U_A20;
      end
      // region 1 advance
      U_A10: begin
        w.jc = JC_DEC_NEG; w.jt = U_A12;
      end
      U_A11: begin
        w.row_dec = 1'b1; w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_ROWDEC;
      end
      U_A11B: begin
        w.dop = DO_SUB; w.dsrc = DS_PROD; w.dsh = 2'd2;
      end
      U_A12: begin
        w.dop = DO_ADD; w.dsrc = DS_B; w.dsh = 2'd1;
        w.mul_en = 1'b1; w.oa = OA_B; w.ob = OB_COL;
      end
      U_A13: begin
        w.dop = DO_ADD; w.dsrc = DS_PROD; w.dsh = 2'd2; w.col_inc = 1'b1;
      end
      U_A14: begin
        w.dop = DO_ADD; w.dsrc = DS_B; w.dsh = 2'd2;
        w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_ROW;
        w.jc = JC_ALWAYS; w.jt = U_CK1;
      end
      // region 2 advance
      U_A20: begin
        w.jc = JC_ROW_ZERO; w.jt = U_KILL;
      end
      U_A21: begin
        w.jc = JC_DEC_POS; w.jt = U_A24;
      end
      U_A22: begin
        w.col_inc = 1'b1;
      end
      U_A23: begin
        w.mul_en = 1'b1; w.oa = OA_B; w.ob = OB_COL;
      end
      U_A23B: begin
        w.dop = DO_ADD; w.dsrc = DS_PROD; w.dsh = 2'd2;
      end
      U_A24: begin
        w.row_dec = 1'b1; w.mul_en = 1'b1; w.oa = OA_A; w.ob = OB_ROWDEC;
        w.dop = DO_ADD; w.dsrc = DS_A; w.dsh = 2'd1;
      end
      U_A25: begin
        w.dop = DO_ADD; w.dsrc = DS_A; w.dsh = 2'd2;
      end
      U_A26: begin
        w.dop = DO_SUB; w.dsrc = DS_PROD; w.dsh = 2'd2; w.fin = 1'b1;
      end
      U_KILL: begin
        w.clr_active = 1'b1; w.fin = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mes_if.sv =====
// Valid/ready channel interfaces for the ellipse stepper input and result words.
`default_nettype none

interface mes_in_if #(
  parameter int unsigned COORD_WIDTH = mes_pkg::COORD_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [COORD_WIDTH-1:0] center_x;
  logic [COORD_WIDTH-1:0] center_y;
  logic [COORD_WIDTH-2:0] semi_a;
  logic [COORD_WIDTH-2:0] semi_b;

  modport source (output valid, mode, center_x, center_y, semi_a, semi_b, input ready);
  modport sink   (input valid, mode, center_x, center_y, semi_a, semi_b, output ready);
endinterface

interface mes_out_if #(
  parameter int unsigned COORD_WIDTH = mes_pkg::COORD_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic        [COORD_WIDTH:0] x_plus;
  logic signed [COORD_WIDTH:0] x_minus;
  logic        [COORD_WIDTH:0] y_plus;
  logic signed [COORD_WIDTH:0] y_minus;
  logic                        last_point;

  modport source (output valid, x_plus, x_minus, y_plus, y_minus, last_point, input ready);
  modport sink   (input valid, x_plus, x_minus, y_plus, y_minus, last_point, output ready);
endinterface

`default_nettype wire

// ===== sv/midpoint_ellipse_stepper.sv =====
// Midpoint ellipse rasterizer: start and step words in, mirrored point words out.
//
// Input channel: mode 0 (start) latches center and semi-axes, places the point at
// column 0, row semi_b and yields the first point; mode 1 (step) yields the current
// point and moves on. A step word while no ellipse is active is taken and dropped.
// Output channel: x/y plus and minus coordinates of the current point, last_point
// set on the final row-0 point; step words after that yield nothing.
// A microcode sequencer drives one shared multiplier (one product per cycle, each
// registered) and a 50-bit decision accumulator. A step word's result is emitted
// first, then the point advances while the block is held; in region 1 the advance
// may cross into region 2, where the decision value is rebuilt. A start word holds
// the block while the squares and the decision value are seeded, its first point is
// emitted and the point advances. The input side is ready whenever the sequencer
// is idle.
// The result sits in an output register; while the receiver stalls, the next word
// is still taken and worked up to its emit step, where the sequencer waits.
// Reset leaves the block idle with no ellipse active and the output empty.
`default_nettype none

module midpoint_ellipse_stepper #(
  parameter int unsigned COORD_WIDTH = mes_pkg::COORD_WIDTH_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  mes_in_if.sink     in_i,
  mes_out_if.source  out_o
);

  mes_pkg::dp_ctl_t  ctl;
  mes_pkg::dp_stat_t stat;
  logic              in_ready;

  mes_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .ctl_o      (ctl)
  );

  mes_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .center_x_i   (in_i.center_x),
    .center_y_i   (in_i.center_y),
    .semi_a_i     (in_i.semi_a),
    .semi_b_i     (in_i.semi_b),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .x_plus_o     (out_o.x_plus),
    .x_minus_o    (out_o.x_minus),
    .y_plus_o     (out_o.y_plus),
    .y_minus_o    (out_o.y_minus),
    .last_point_o (out_o.last_point)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

// ===== sv/mes_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module mes_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_mode_i,
  input  wire mes_pkg::dp_stat_t stat_i,
  output logic                   in_ready_o,
  output mes_pkg::dp_ctl_t       ctl_o
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e          state_q;
  mes_pkg::pc_t    pc_q;
  logic            start_q;

  mes_pkg::uword_t uw;
  logic            stall;
  logic            accept;
  logic            take;

  always_comb begin
    uw         = mes_pkg::ucode(pc_q);
    // hold the emit step while the result register is still occupied
    stall      = uw.emit && stat_i.out_busy;
    in_ready_o = (state_q == S_IDLE);
    accept     = in_valid_i && in_ready_o;

    case (uw.jc)
      mes_pkg::JC_NONE:     take = 1'b0;
      mes_pkg::JC_ALWAYS:   take = 1'b1;
      mes_pkg::JC_CMP_GT:   take = stat_i.cmp_gt;
      mes_pkg::JC_DEC_NEG:  take = stat_i.dec_neg;
      mes_pkg::JC_DEC_POS:  take = stat_i.dec_pos;
      mes_pkg::JC_R2:       take = stat_i.in_r2;
      mes_pkg::JC_START:    take = start_q;
      mes_pkg::JC_ROW_ZERO: take = stat_i.row_zero;
      default:              take = 1'b0;
    endcase

    ctl_o.run        = (state_q == S_RUN) && !stall;
    ctl_o.load_start = accept && (in_mode_i == mes_pkg::MODE_START);
    ctl_o.uw         = uw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= mes_pkg::U_ST0;
      start_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_mode_i == mes_pkg::MODE_START) begin
              state_q <= S_RUN;
              pc_q    <= mes_pkg::U_ST0;
              start_q <= 1'b1;
            end else if (stat_i.active) begin
              state_q <= S_RUN;
              pc_q    <= mes_pkg::U_EM;
            end
          end
        end
        S_RUN: begin
          if (!stall) begin
            if (uw.emit) begin
              start_q <= 1'b0;
            end
            if (take) begin
              pc_q <= uw.jt;
            end else if (uw.fin) begin
              state_q <= S_IDLE;
            end else begin
              pc_q <= pc_q + mes_pkg::pc_t'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/mes_dp.sv =====
// Datapath: shared multiplier, decision accumulator, point registers and result register.
`default_nettype none

module mes_dp #(
  parameter int unsigned COORD_WIDTH = mes_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mes_pkg::dp_ctl_t            ctl_i,
  output mes_pkg::dp_stat_t                stat_o,
  input  wire logic [COORD_WIDTH-1:0]      center_x_i,
  input  wire logic [COORD_WIDTH-1:0]      center_y_i,
  input  wire logic [COORD_WIDTH-2:0]      semi_a_i,
  input  wire logic [COORD_WIDTH-2:0]      semi_b_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic        [COORD_WIDTH:0]      x_plus_o,
  output logic signed [COORD_WIDTH:0]      x_minus_o,
  output logic        [COORD_WIDTH:0]      y_plus_o,
  output logic signed [COORD_WIDTH:0]      y_minus_o,
  output logic                             last_point_o
);

  localparam int unsigned SQ_W   = 2 * (COORD_WIDTH - 1);
  localparam int unsigned OPB_W  = 2 * (COORD_WIDTH + 1);
  localparam int unsigned PROD_W = SQ_W + OPB_W;
  localparam int unsigned DEC_W  = mes_pkg::DEC_W;

  logic [COORD_WIDTH-1:0] hx_q, hy_q;
  logic [COORD_WIDTH-2:0] sa_q, sb_q;
  logic [SQ_W-1:0]        a_sq_q, b_sq_q;
  logic [COORD_WIDTH-1:0] col_q;
  logic [COORD_WIDTH:0]   row_q;
  logic [DEC_W-1:0]       dec_q;
  logic [PROD_W-1:0]      prod_q, tmp_q;
  logic                   active_q, r2_q, out_valid_q;

  logic [COORD_WIDTH:0]   row_dec, rm1, c1;
  logic [COORD_WIDTH-2:0] bm1;
  logic [SQ_W-1:0]        op_a;
  logic [OPB_W-1:0]       op_b;
  logic [PROD_W-1:0]      mul_res;
  logic [DEC_W-1:0]       dsrc, dsh_val, dec_d;
  logic                   row_zero;
  mes_pkg::uword_t        uw;

  always_comb begin
    uw       = ctl_i.uw;
    row_zero = (row_q == '0);
    row_dec  = row_q - (COORD_WIDTH + 1)'(1);
    // |row - 1|: the square only needs the magnitude
    rm1      = row_zero ? (COORD_WIDTH + 1)'(1) : row_dec;
    c1       = {1'b0, col_q} + (COORD_WIDTH + 1)'(1);
    bm1      = sb_q - (COORD_WIDTH - 1)'(1);

    case (uw.oa)
      mes_pkg::OA_SEMA: op_a = SQ_W'(sa_q);
      mes_pkg::OA_SEMB: op_a = SQ_W'(sb_q);
      mes_pkg::OA_BM1:  op_a = SQ_W'(bm1);
      mes_pkg::OA_A:    op_a = a_sq_q;
      mes_pkg::OA_B:    op_a = b_sq_q;
      mes_pkg::OA_C1:   op_a = SQ_W'(c1);
      mes_pkg::OA_RM1:  op_a = SQ_W'(rm1);
      default:          op_a = '0;
    endcase

    case (uw.ob)
      mes_pkg::OB_SEMA:   op_b = OPB_W'(sa_q);
      mes_pkg::OB_SEMB:   op_b = OPB_W'(sb_q);
      mes_pkg::OB_PROD:   op_b = prod_q[OPB_W-1:0];
      mes_pkg::OB_ROW:    op_b = OPB_W'(row_q);
      mes_pkg::OB_ROWDEC: op_b = OPB_W'(row_dec);
      mes_pkg::OB_COL:    op_b = OPB_W'(col_q);
      mes_pkg::OB_RM1:    op_b = OPB_W'(rm1);
      mes_pkg::OB_B:      op_b = OPB_W'(b_sq_q);
      default:            op_b = '0;
    endcase

    mul_res = PROD_W'(op_a) * PROD_W'(op_b);

    case (uw.dsrc)
      mes_pkg::DS_PROD: dsrc = DEC_W'(prod_q);
      mes_pkg::DS_A:    dsrc = DEC_W'(a_sq_q);
      mes_pkg::DS_B:    dsrc = DEC_W'(b_sq_q);
      default:          dsrc = '0;
    endcase
    dsh_val = dsrc << uw.dsh;

    // decision wraps modulo 2^DEC_W
    case (uw.dop)
      mes_pkg::DO_HOLD: dec_d = dec_q;
      mes_pkg::DO_LOAD: dec_d = dsh_val;
      mes_pkg::DO_ADD:  dec_d = dec_q + dsh_val;
      mes_pkg::DO_SUB:  dec_d = dec_q - dsh_val;
      default:          dec_d = dec_q;
    endcase

    stat_o.active   = active_q;
    stat_o.in_r2    = r2_q;
    stat_o.row_zero = row_zero;
    stat_o.dec_neg  = dec_q[DEC_W-1];
    stat_o.dec_pos  = !dec_q[DEC_W-1] && (dec_q != '0);
    stat_o.cmp_gt   = (tmp_q > prod_q);
    stat_o.out_busy = out_valid_q && !out_ready_i;
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_start) begin
      hx_q  <= center_x_i;
      hy_q  <= center_y_i;
      sa_q  <= semi_a_i;
      sb_q  <= semi_b_i;
      col_q <= '0;
      row_q <= (COORD_WIDTH + 1)'(semi_b_i);
    end
    if (ctl_i.run) begin
      if (uw.mul_en) begin
        prod_q <= mul_res;
      end
      if (uw.ld_a) begin
        a_sq_q <= prod_q[SQ_W-1:0];
      end
      if (uw.ld_b) begin
        b_sq_q <= prod_q[SQ_W-1:0];
      end
      if (uw.ld_tmp) begin
        tmp_q <= prod_q;
      end
      if (uw.dop != mes_pkg::DO_HOLD) begin
        dec_q <= dec_d;
      end
      if (uw.row_dec) begin
        row_q <= row_dec;
      end
      if (uw.col_inc) begin
        col_q <= col_q + COORD_WIDTH'(1);
      end
      if (uw.emit) begin
        x_plus_o     <= {1'b0, hx_q} + {1'b0, col_q};
        x_minus_o    <= $signed({1'b0, hx_q} - {1'b0, col_q});
        y_plus_o     <= {1'b0, hy_q} + row_q;
        y_minus_o    <= $signed({1'b0, hy_q} - row_q);
        last_point_o <= r2_q && row_zero;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      r2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.load_start) begin
        active_q <= 1'b1;
        r2_q     <= 1'b0;
      end else if (ctl_i.run) begin
        if (uw.clr_active) begin
          active_q <= 1'b0;
        end
        if (uw.set_r2) begin
          r2_q <= 1'b1;
        end
      end
      if (ctl_i.run && uw.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/mes_checker.sv =====
// Port-level assertions for the ellipse stepper, bound to the top level.
`default_nettype none

module mes_checker #(
  parameter int unsigned COORD_WIDTH = mes_pkg::COORD_WIDTH_DEF
) (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_i,
  input wire logic                    in_mode_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_ready_i,
  input wire logic [COORD_WIDTH:0]    x_plus_i,
  input wire logic [COORD_WIDTH:0]    x_minus_i,
  input wire logic [COORD_WIDTH:0]    y_plus_i,
  input wire logic [COORD_WIDTH:0]    y_minus_i,
  input wire logic                    last_point_i
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(x_plus_i) && $stable(y_plus_i)
      && $stable(last_point_i))
    else $error("result word changed while stalled");

  // a start word always keeps the sequencer busy for the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == mes_pkg::MODE_START) |=> !in_ready_i)
    else $error("input ready right after a start word");

  // the closing point sits on the center row
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_point_i |-> y_plus_i == y_minus_i)
    else $error("last point off the center row");

  // plus and minus coordinates sum to twice the center, so their low bits agree
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (x_plus_i[0] == x_minus_i[0]) && (y_plus_i[0] == y_minus_i[0]))
    else $error("mirrored coordinates inconsistent");

endmodule

bind midpoint_ellipse_stepper mes_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_mes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_mode_i    (in_i.mode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .x_plus_i     (out_o.x_plus),
  .x_minus_i    (out_o.x_minus),
  .y_plus_i     (out_o.y_plus),
  .y_minus_i    (out_o.y_minus),
  .last_point_i (out_o.last_point)
);

`default_nettype wire
